[rtl/aging_priority_deadline_scheduler_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the aging priority deadline scheduler
// Shared same-cycle-implication and next-cycle-implication assertion forms.
// ---------------------------------------------------------------------------
`ifndef AGING_PRIORITY_DEADLINE_SCHEDULER_UNIT_DEFINES_SVH
`define AGING_PRIORITY_DEADLINE_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define APS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aps_pkg.sv]
// ---------------------------------------------------------------------------
// aps_pkg
// Types, codes and helpers for the aging priority deadline scheduler.
// ---------------------------------------------------------------------------
package aps_pkg;

  localparam int DL_W      = 20;  // deadline field width
  localparam int Q_W       = 32;  // Q16.16 score width
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_PICK = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_FIFO     = 2'd0,
    MODE_PRIO     = 2'd1,
    MODE_DEADLINE = 2'd2,
    MODE_HYBRID   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY  = 3'd0,
    CFG_URGENCY = 3'd1,
    CFG_RESUME  = 3'd2,
    CFG_LATENCY = 3'd3,
    CFG_AGING   = 3'd4,
    CFG_TOKEN   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_LATCH,
    S_DIV,
    S_MUL,
    S_SUM,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [7:0]          job_tag;
    logic signed [15:0]  base_priority;
    logic signed [31:0]  eff_prio;
    logic [DL_W-1:0]     due_ms;
    logic                is_resume;
    logic                is_latency_sensitive;
    logic [15:0]         token_budget;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] picked_tag;
    logic [4:0] occupancy;
  } result_t;

  // one stored job
  typedef struct packed {
    logic [7:0]          tag;
    logic signed [15:0]  base_priority;
    logic signed [31:0]  eff_prio;
    logic [DL_W-1:0]     due_ms;
    logic                is_resume;
    logic                is_latency_sensitive;
    logic [15:0]         token_budget;
    logic [31:0]         enq_time;
  } job_rec_t;

  typedef struct packed {
    logic            start;
    logic [31:0]     dividend;
    logic [DL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/aps_ram.sv]
// ---------------------------------------------------------------------------
// aps_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module aps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/aps_div.sv]
// ---------------------------------------------------------------------------
// aps_div
// Radix-2 restoring divider: 32-bit unsigned dividend by a deadline-width
// divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module aps_div (
  input  logic              clk,
  input  logic              rst,
  input  aps_pkg::div_req_t req,
  output aps_pkg::div_rsp_t rsp
);
  import aps_pkg::*;

  localparam int DW  = 32;
  localparam int CNW = $clog2(DW + 1);

  logic [DL_W:0]    rem;
  logic [DW-1:0]    quo;
  logic [DL_W-1:0]  dvs;
  logic [CNW-1:0]   cnt;
  logic             done;
  logic [DL_W:0]    trial;
  logic             fits;

  // shift next dividend bit into the partial remainder
  always_comb begin
    trial = {rem[DL_W-1:0], quo[DW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNW'(DW);
      end else if (cnt != '0) begin
        cnt  <= cnt - CNW'(1);
        done <= (cnt == CNW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      rem <= fits ? (trial - {1'b0, dvs}) : trial;
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[rtl/aging_priority_deadline_scheduler_unit.sv]
// ---------------------------------------------------------------------------
// aging_priority_deadline_scheduler_unit
// Bounded job store with fifo, priority, deadline and hybrid pick policies.
// ---------------------------------------------------------------------------
// Jobs live in one RAM in arrival order. Enqueue, tick, unused ops and an
// empty pick need no scan: done pulses on the cycle after start. A pick walks
// the occupied slots one at a time; each slot goes through read, latch,
// urgency divide, multiply, sum and compare, then the slots behind the winner
// close up one by one, each with a read and a write. The result shows for
// exactly one cycle with done high and must be taken then. Configuration
// writes are always ready and belong to idle periods.
module aging_priority_deadline_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  aps_pkg::cmd_t                     cmd,
  output logic                              done,
  output aps_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import aps_pkg::*;
  `include "aging_priority_deadline_scheduler_unit_defines.svh"

  localparam int IW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CW1 = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  state_t state, state_next;

  logic [CW-1:0]      job_count;
  logic [31:0]        clock_ms;
  logic [1:0]         policy_mode;
  logic signed [31:0] urgency_weight, resume_boost, latency_boost;
  logic signed [31:0] aging_per_ms, token_penalty;

  logic [IW-1:0]      idx, sidx;
  job_rec_t           cur;
  logic [31:0]        cur_wait;
  logic signed [64:0] prod_age;
  logic signed [48:0] prod_tok;
  logic signed [31:0] urg, sat_age, sat_tok;
  logic signed [33:0] part_sum;
  logic signed [31:0] win_score;
  logic [31:0]        best_wait;
  logic [IW-1:0]      win_idx;
  logic [7:0]         best_tag;

  // ram and divider hookup
  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  job_rec_t           ram_wdata, rd_data;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               div_start;

  logic               accept, fin, more, better;
  logic [31:0]        lat_wait;
  logic [DL_W-1:0]    lat_rem;
  logic signed [35:0] total;
  logic signed [31:0] score;
  job_rec_t           enq_rec;

  aps_ram #(.WIDTH($bits(job_rec_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  aps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // new job record, stamped with the clock
  always_comb begin
    enq_rec.tag                  = cmd.job_tag;
    enq_rec.base_priority        = cmd.base_priority;
    enq_rec.eff_prio             = cmd.eff_prio;
    enq_rec.due_ms               = cmd.due_ms;
    enq_rec.is_resume            = cmd.is_resume;
    enq_rec.is_latency_sensitive = cmd.is_latency_sensitive;
    enq_rec.token_budget         = cmd.token_budget;
    enq_rec.enq_time             = clock_ms;
  end

  // wait and urgency divisor of the slot just read
  always_comb begin
    lat_wait = clock_ms - rd_data.enq_time;
    if (lat_wait >= {{(32-DL_W){1'b0}}, rd_data.due_ms}) begin
      lat_rem = DL_W'(1);
    end else begin
      lat_rem = rd_data.due_ms - lat_wait[DL_W-1:0];
    end
    div_req.start    = div_start;
    div_req.dividend = urgency_weight[31] ? 32'(-urgency_weight) : urgency_weight;
    div_req.divisor  = lat_rem;
  end

  // score of the current slot and the tie-broken comparison
  always_comb begin
    total = 36'(part_sum) + 36'(sat_age) - 36'(sat_tok);
    case (policy_mode)
      MODE_PRIO:     score = 32'(cur.base_priority);
      MODE_DEADLINE: score = urg;
      MODE_HYBRID:   score = sat32(66'(total));
      default:       score = '0;
    endcase
    if (idx == '0) begin
      better = 1'b1;
    end else if (policy_mode != MODE_FIFO && score != win_score) begin
      better = score > win_score;
    end else begin
      better = cur_wait > best_wait;
    end
    more = (CW1'(idx) + CW1'(1)) < CW1'(job_count);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = job_count[IW-1:0];
    ram_wdata  = enq_rec;
    ram_raddr  = idx;
    div_start  = 1'b0;
    fin        = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && cmd.op == OP_PICK && job_count != '0) begin
          state_next = S_SCAN_RD;
        end
        if (accept && cmd.op == OP_ENQ && job_count < DEPTH_C) begin
          ram_we = 1'b1;
        end
      end
      S_SCAN_RD:    state_next = S_SCAN_LATCH;
      S_SCAN_LATCH: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_SUM;
      S_SUM: state_next = S_CMP;
      S_CMP: begin
        if (more) begin
          state_next = S_SCAN_RD;
        end else if ((CW1'(better ? idx : win_idx) + CW1'(1)) < CW1'(job_count)) begin
          state_next = S_SHIFT_RD;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        ram_raddr  = IW'(sidx + IW'(1));
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sidx;
        ram_wdata = rd_data;
        if ((CW1'(sidx) + CW1'(2)) < CW1'(job_count)) begin
          state_next = S_SHIFT_RD;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state: count, clock, configuration, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count      <= '0;
      clock_ms       <= '0;
      done           <= 1'b0;
      policy_mode    <= MODE_FIFO;
      urgency_weight <= '0;
      resume_boost   <= '0;
      latency_boost  <= '0;
      aging_per_ms   <= '0;
      token_penalty  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLICY:  policy_mode    <= cfg_data[1:0];
          CFG_URGENCY: urgency_weight <= cfg_data;
          CFG_RESUME:  resume_boost   <= cfg_data;
          CFG_LATENCY: latency_boost  <= cfg_data;
          CFG_AGING:   aging_per_ms   <= cfg_data;
          CFG_TOKEN:   token_penalty  <= cfg_data;
          default: ;
        endcase
      end
      // a non-empty pick reports when the scan finishes
      if (accept) begin
        done <= !(cmd.op == OP_PICK && job_count != '0);
      end else begin
        done <= fin;
      end
      if (accept && cmd.op == OP_ENQ && job_count < DEPTH_C) begin
        job_count <= job_count + CW'(1);
      end else if (fin) begin
        job_count <= job_count - CW'(1);
      end
      if (accept && cmd.op == OP_TICK) begin
        clock_ms <= clock_ms + 32'd1;
      end
    end
  end

  // result and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      result.picked_tag <= '0;
      idx               <= '0;
      if (cmd.op == OP_ENQ && job_count < DEPTH_C) begin
        result.status    <= ST_OK;
        result.occupancy <= 5'(job_count + CW'(1));
      end else begin
        result.status    <= (cmd.op == OP_ENQ) ? ST_DROP :
                            (cmd.op == OP_PICK && job_count == '0) ? ST_EMPTY : ST_OK;
        result.occupancy <= 5'(job_count);
      end
    end
    if (fin) begin
      result.status     <= ST_OK;
      result.picked_tag <= (state == S_CMP && better) ? cur.tag : best_tag;
      result.occupancy  <= 5'(job_count - CW'(1));
    end
    case (state)
      S_SCAN_LATCH: begin
        cur      <= rd_data;
        cur_wait <= lat_wait;
      end
      S_MUL: begin
        prod_age <= $signed({1'b0, cur_wait}) * aging_per_ms;
        prod_tok <= $signed({1'b0, cur.token_budget}) * token_penalty;
        if (cur.due_ms == '0) begin
          urg <= '0;
        end else begin
          urg <= urgency_weight[31] ? -div_rsp.quotient : div_rsp.quotient;
        end
      end
      S_SUM: begin
        sat_age  <= sat32(66'(prod_age));
        sat_tok  <= sat32(66'(prod_tok));
        part_sum <= 34'(cur.eff_prio) + 34'(urg)
                  + (cur.is_resume ? 34'(resume_boost) : 34'sd0)
                  + (cur.is_latency_sensitive ? 34'(latency_boost) : 34'sd0);
      end
      S_CMP: begin
        if (better) begin
          win_score <= score;
          best_wait <= cur_wait;
          win_idx   <= idx;
          best_tag  <= cur.tag;
        end
        sidx <= better ? idx : win_idx;
        if (more) begin
          idx <= idx + IW'(1);
        end
      end
      S_SHIFT_WR: sidx <= sidx + IW'(1);
      default: ;
    endcase
  end

  // checks
  `APS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, job_count <= DEPTH_C, "job count over depth")
  `APS_ASSERT_NXT(a_accept_moves, clk, rst, accept, busy || done, "accepted item stalled")
  `APS_ASSERT_IMP(a_drop_full, clk, rst, done && result.status == ST_DROP, job_count == DEPTH_C, "drop while not full")
  `APS_ASSERT_IMP(a_shift_range, clk, rst, state == S_SHIFT_WR, (CW1'(sidx) + CW1'(1)) < CW1'(job_count), "shift past last job")

endmodule

[dv/aging_priority_deadline_scheduler_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aging_priority_deadline_scheduler_unit_tb
// Drives enqueue, pick and tick items through the scheduler under every pick
// policy and a range of weight settings. A behavioral job store predicts the
// results, directed rows may carry fixed ones; all are matched field by field in order.
// ---------------------------------------------------------------------------
module aging_priority_deadline_scheduler_unit_tb;
  import aps_pkg::*;

  localparam int          DEPTH     = 16;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int          PHASES    = 7;
  localparam int          PHASE_LEN = 100;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    done;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  aging_priority_deadline_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow job store and registers
  job_rec_t           jobs [DEPTH];
  int                 job_cnt = 0;
  logic [31:0]        now_ms = '0;
  mode_t              pol = MODE_FIFO;
  logic signed [31:0] w_urg = '0, w_res = '0, w_lat = '0, w_age = '0, w_tok = '0;

  result_t pending_results[$];
  int      fails = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint waited(job_rec_t j);
    logic [31:0] w;
    w = now_ms - j.enq_time;
    return longint'(w);
  endfunction

  function automatic longint urgency(job_rec_t j);
    longint rem;
    if (j.due_ms == '0) return 0;
    rem = longint'(j.due_ms) - waited(j);
    if (rem < 1) rem = 1;
    return longint'(w_urg) / rem;
  endfunction

  function automatic longint job_score(job_rec_t j);
    longint s;
    if (pol == MODE_PRIO) return longint'(j.base_priority);
    if (pol == MODE_DEADLINE) return urgency(j);
    s = longint'(j.eff_prio) + urgency(j);
    if (j.is_resume) s += longint'(w_res);
    if (j.is_latency_sensitive) s += longint'(w_lat);
    s += clamp32(waited(j) * longint'(w_age));
    s -= clamp32(longint'(j.token_budget) * longint'(w_tok));
    return clamp32(s);
  endfunction

  // apply one accepted item to the shadow store, return its result
  function automatic result_t schedule_step(cmd_t c);
    result_t r;
    int      best;
    longint  bs, cs;
    r = '0;
    case (c.op)
      OP_ENQ: begin
        if (job_cnt >= DEPTH) begin
          r.status = ST_DROP;
        end else begin
          jobs[job_cnt] = '{c.job_tag, c.base_priority, c.eff_prio,
                            c.due_ms, c.is_resume, c.is_latency_sensitive,
                            c.token_budget, now_ms};
          job_cnt++;
        end
      end
      OP_PICK: begin
        if (job_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < job_cnt; i++) begin
            if (pol != MODE_FIFO) begin
              cs = job_score(jobs[i]);
              bs = job_score(jobs[best]);
              if (cs != bs) begin
                if (cs > bs) best = i;
                continue;
              end
            end
            if (waited(jobs[i]) > waited(jobs[best])) best = i;
          end
          r.picked_tag = jobs[best].tag;
          for (int i = best; i + 1 < job_cnt; i++) jobs[i] = jobs[i+1];
          job_cnt--;
        end
      end
      OP_TICK: now_ms = now_ms + 32'd1;
      default: ;
    endcase
    r.occupancy = job_cnt[4:0];
    return r;
  endfunction

  // send one item after a gap; start stays high when the gap is zero
  task automatic issue_item(cmd_t c, int gap, bit typed, result_t typed_res);
    result_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    // busy is settled mid-cycle; the next rising edge accepts the item
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    r = schedule_step(c);
    pending_results = {pending_results, (typed ? typed_res : r)};
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POLICY:  pol = mode_t'(val[1:0]);
      CFG_URGENCY: w_urg = val;
      CFG_RESUME:  w_res = val;
      CFG_LATENCY: w_lat = val;
      CFG_AGING:   w_age = val;
      CFG_TOKEN:   w_tok = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_weight(int phase);
    case (phase == 0 ? 0 : $urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t    c;
    int unsigned sel;
    c = '0;
    c.job_tag              = 8'($urandom);
    c.base_priority        = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 7));
    c.eff_prio             = $urandom;
    c.is_resume            = 1'($urandom);
    c.is_latency_sensitive = 1'($urandom);
    c.token_budget         = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20));
    case ($urandom_range(0, 3))
      0: c.due_ms = '0;
      1: c.due_ms = DL_W'($urandom);
      default: c.due_ms = DL_W'($urandom_range(1, 40));
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 42) c.op = OP_ENQ;
    else if (sel < 75) c.op = OP_PICK;
    else if (sel < 95) c.op = OP_TICK;
    else c.op = OP_UNUSED;
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d tag %0d occupancy %0d",
               result.status, result.picked_tag, result.occupancy);
        fails++;
      end else begin
        automatic result_t want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fails++;
        end
        if (result.picked_tag !== want.picked_tag) begin
          $error("picked_tag: expected %0d, got %0d", want.picked_tag, result.picked_tag);
          fails++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, result.occupancy);
          fails++;
        end
      end
    end
  end

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t res;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    mode_t     modes[PHASES] = '{MODE_FIFO, MODE_PRIO, MODE_DEADLINE, MODE_HYBRID,
                                 MODE_HYBRID, MODE_DEADLINE, MODE_PRIO};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pick, field extremes, tick, unused op, fill and overflow
    row = '{'0, 1'b1, '{ST_EMPTY, 8'd0, 5'd0}};
    row.c.op = OP_PICK;
    rows = {rows, row};
    row = '{'1, 1'b1, '{ST_OK, 8'd0, 5'd1}};
    row.c.op = OP_ENQ;
    rows = {rows, row};
    row = '{'0, 1'b1, '{ST_OK, 8'd0, 5'd2}};
    row.c.op = OP_ENQ;
    rows = {rows, row};
    row = '{'0, 1'b1, '{ST_OK, 8'd0, 5'd2}};
    row.c.op = OP_TICK;
    rows = {rows, row};
    row = '{'0, 1'b1, '{ST_OK, 8'd0, 5'd2}};
    row.c.op = OP_UNUSED;
    rows = {rows, row};
    for (int i = 0; i < 14; i++) begin
      row = '{rand_cmd(), 1'b0, '0};
      row.c.op = OP_ENQ;
      rows = {rows, row};
    end
    row = '{'1, 1'b1, '{ST_DROP, 8'd0, 5'd16}};
    row.c.op = OP_ENQ;
    rows = {rows, row};
    row = '{'0, 1'b0, '0};
    row.c.op = OP_PICK;
    rows = {rows, row};
    foreach (rows[i])
      issue_item(rows[i].c, $urandom_range(0, 8), rows[i].typed, rows[i].res);
    drain();

    // random phases, each under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_POLICY, {30'd0, modes[p]});
      write_reg(CFG_URGENCY, pick_weight(p));
      write_reg(CFG_RESUME, pick_weight(p));
      write_reg(CFG_LATENCY, pick_weight(p));
      write_reg(CFG_AGING, p == 4 ? 32'h8000_0000 : pick_weight(p));
      write_reg(CFG_TOKEN, p == 4 ? 32'h7FFF_FFFF : pick_weight(p));
      for (int n = 0; n < PHASE_LEN; n++)
        issue_item(rand_cmd(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8),
                   1'b0, '0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

endmodule
